// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file ues_checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define UES_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define UES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ues_pkg.sv =====
// Shared types, constants and helpers for the unicycle Euler step core.
// No dependencies.
package ues_pkg;

    localparam int WORD_W  = 32;
    localparam int ANG_W   = 34;
    localparam int MAX_TAB = 30;

    localparam int TWO_PI_Q  = 411775;
    localparam int PI_Q      = 205887;
    localparam int HALF_PI_Q = 102944;

    // floor(2^50 / 2pi) and 2^31 mod 2pi, for the reciprocal reduction
    localparam logic [31:0] RECIP_M = 32'((64'd1 << 50) / 64'(TWO_PI_Q));
    localparam int MOD_OFFSET_K = int'((64'd1 << 31) % 64'(TWO_PI_Q));

    localparam logic [15:0] STEP_RESET = 16'd655;
    localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] ATAN_TAB [MAX_TAB] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef struct packed {
        logic signed [WORD_W-1:0] px;
        logic signed [WORD_W-1:0] py;
        logic signed [WORD_W-1:0] th;
        logic signed [WORD_W-1:0] sp;
        logic signed [WORD_W-1:0] wr;
        logic signed [WORD_W-1:0] ac;
        logic signed [WORD_W-1:0] tc;
    } side_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        return signed'({2'b00, ATAN_TAB[idx]});
    endfunction

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/ues_if.sv =====
// Valid/ready channel interfaces for the input state and the stepped state.
// Depends on nothing.
interface ues_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] speed;
    logic signed [31:0] turn_rate;
    logic signed [31:0] accel_cmd;
    logic signed [31:0] turn_accel_cmd;

    modport source (output valid, pos_x, pos_y, heading, speed, turn_rate,
                    accel_cmd, turn_accel_cmd, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, speed, turn_rate,
                    accel_cmd, turn_accel_cmd, output ready);
endinterface

interface ues_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] next_pos_x;
    logic signed [31:0] next_pos_y;
    logic signed [31:0] next_heading;
    logic signed [31:0] next_speed;
    logic signed [31:0] next_turn_rate;

    modport source (output valid, next_pos_x, next_pos_y, next_heading, next_speed,
                    next_turn_rate, input ready);
    modport sink   (input valid, next_pos_x, next_pos_y, next_heading, next_speed,
                    next_turn_rate, output ready);
endinterface

// ===== hw/rtl/ues_angle_reduce.sv =====
// Four-stage heading reduction to [-pi/2, pi/2] with a quadrant flag.
// Depends on ues_pkg.
module ues_angle_reduce
    import ues_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  side_t                   in_side,
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] out_z,
    output logic                    out_neg,
    output side_t                   out_side
);

    logic [3:0]  vld_reg;
    logic [31:0] u1_reg, u2_reg;
    logic [63:0] p_reg;
    logic [32:0] qc_reg;
    logic [19:0] r_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic        neg_reg;
    side_t       s1_reg, s2_reg, s3_reg, s4_reg;

    logic [31:0] u_in;
    logic [13:0] q;
    logic [19:0] r0, r1;
    logic signed [20:0] r2, r3, rs, rf;
    logic        neg_next;
    logic signed [ANG_W-1:0] z_next;
    logic [19:0] r_next;

    // Offset binary makes the floor modulo of a signed value an unsigned one
    assign u_in = {~in_side.th[31], in_side.th[30:0]};
    assign q    = p_reg[63:50];

    always_comb
    begin
        r0 = 20'(u2_reg - qc_reg[31:0]);
        r1 = (r0 >= 20'(TWO_PI_Q)) ? r0 - 20'(TWO_PI_Q) : r0;
        r2 = signed'({1'b0, r1}) - 21'(MOD_OFFSET_K);
        r3 = (r2 < 0) ? r2 + 21'(TWO_PI_Q) : r2;
        r_next = r3[19:0];
    end

    always_comb
    begin
        rs = signed'({1'b0, r_reg});
        if (rs > 21'(PI_Q))
            rs = rs - 21'(TWO_PI_Q);
        neg_next = 1'b0;
        rf = rs;
        if (rs > 21'(HALF_PI_Q))
        begin
            rf = rs - 21'(PI_Q);
            neg_next = 1'b1;
        end
        else if (rs < -21'(HALF_PI_Q))
        begin
            rf = rs + 21'(PI_Q);
            neg_next = 1'b1;
        end
        z_next = {{2{rf[20]}}, rf[17:0], 14'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u1_reg  <= u_in;
            p_reg   <= 64'(u_in) * 64'(RECIP_M);
            s1_reg  <= in_side;
            u2_reg  <= u1_reg;
            qc_reg  <= 33'(q) * 33'(TWO_PI_Q);
            s2_reg  <= s1_reg;
            r_reg   <= r_next;
            s3_reg  <= s2_reg;
            z_reg   <= z_next;
            neg_reg <= neg_next;
            s4_reg  <= s3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_z     = z_reg;
    assign out_neg   = neg_reg;
    assign out_side  = s4_reg;

endmodule

// ===== hw/rtl/ues_cordic.sv =====
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, plus a sign stage.
// Depends on ues_pkg.
module ues_cordic
    import ues_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic signed [ANG_W-1:0] in_z,
    input  logic                    in_neg,
    input  side_t                   in_side,
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] out_cos,
    output logic signed [ANG_W-1:0] out_sin,
    output side_t                   out_side
);

    localparam int N = CORDIC_STAGES;

    logic signed [ANG_W-1:0] x_reg [1:N];
    logic signed [ANG_W-1:0] y_reg [1:N];
    logic signed [ANG_W-1:0] z_reg [1:N];
    logic        neg_reg [1:N];
    side_t       side_reg [1:N];
    logic [N:0]  vld_reg;
    logic signed [ANG_W-1:0] cos_reg, sin_reg;
    side_t       sout_reg;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            logic signed [ANG_W-1:0] xi, yi, zi;
            logic  ni, vi;
            side_t si;
            logic  d;

            if (i == 0)
            begin : g_first
                assign xi = GAIN_Q30;
                assign yi = '0;
                assign zi = in_z;
                assign ni = in_neg;
                assign si = in_side;
                assign vi = in_valid;
            end
            else
            begin : g_rest
                assign xi = x_reg[i];
                assign yi = y_reg[i];
                assign zi = z_reg[i];
                assign ni = neg_reg[i];
                assign si = side_reg[i];
                assign vi = vld_reg[i];
            end

            assign d = ~zi[ANG_W-1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i+1] <= 1'b0;
                else if (adv)
                    vld_reg[i+1] <= vi;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg[i+1]    <= d ? xi - (yi >>> i) : xi + (yi >>> i);
                    y_reg[i+1]    <= d ? yi + (xi >>> i) : yi - (xi >>> i);
                    z_reg[i+1]    <= d ? zi - atan_q30(i) : zi + atan_q30(i);
                    neg_reg[i+1]  <= ni;
                    side_reg[i+1] <= si;
                end
            end
        end
    endgenerate

    // Undo the half-turn fold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= vld_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg  <= neg_reg[N] ? -x_reg[N] : x_reg[N];
            sin_reg  <= neg_reg[N] ? -y_reg[N] : y_reg[N];
            sout_reg <= side_reg[N];
        end
    end

    assign out_valid = vld_reg[0];
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_side  = sout_reg;

endmodule

// ===== hw/rtl/ues_scale_sat.sv =====
// Four-stage velocity scaling, step scaling, rounding and saturating sums.
// Depends on ues_pkg.
module ues_scale_sat
    import ues_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic [15:0]              step,
    input  logic                     in_valid,
    input  logic signed [ANG_W-1:0]  in_cos,
    input  logic signed [ANG_W-1:0]  in_sin,
    input  side_t                    in_side,
    output logic                     out_valid,
    output logic signed [WORD_W-1:0] x_res,
    output logic signed [WORD_W-1:0] y_res,
    output logic signed [WORD_W-1:0] th_res,
    output logic signed [WORD_W-1:0] sp_res,
    output logic signed [WORD_W-1:0] wr_res
);

    logic [3:0] vld_reg;
    logic signed [16:0] h;

    logic signed [65:0] pc_reg, ps_reg;
    logic signed [48:0] pw_reg, pa_reg, pt_reg;
    logic signed [WORD_W-1:0] px1_reg, py1_reg, th1_reg, sp1_reg, wr1_reg;

    logic signed [33:0] vx_reg, vy_reg;
    logic signed [WORD_W-1:0] px2_reg, py2_reg, th2_reg, sp2_reg, wr2_reg;

    logic signed [50:0] mx_reg, my_reg;
    logic signed [WORD_W-1:0] px3_reg, py3_reg, th3_reg, sp3_reg, wr3_reg;

    logic signed [WORD_W-1:0] x4_reg, y4_reg, th4_reg, sp4_reg, wr4_reg;

    assign h = signed'({1'b0, step});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pc_reg  <= 66'(in_side.sp) * 66'(in_cos);
            ps_reg  <= 66'(in_side.sp) * 66'(in_sin);
            pw_reg  <= 49'(in_side.wr) * 49'(h);
            pa_reg  <= 49'(in_side.ac) * 49'(h);
            pt_reg  <= 49'(in_side.tc) * 49'(h);
            px1_reg <= in_side.px;
            py1_reg <= in_side.py;
            th1_reg <= in_side.th;
            sp1_reg <= in_side.sp;
            wr1_reg <= in_side.wr;

            // Round half up, then the rate terms close here
            vx_reg  <= 34'((pc_reg + (66'sd1 <<< 29)) >>> 30);
            vy_reg  <= 34'((ps_reg + (66'sd1 <<< 29)) >>> 30);
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            th2_reg <= sat32(64'(th1_reg) + 64'((pw_reg + 49'sd32768) >>> 16));
            sp2_reg <= sat32(64'(sp1_reg) + 64'((pa_reg + 49'sd32768) >>> 16));
            wr2_reg <= sat32(64'(wr1_reg) + 64'((pt_reg + 49'sd32768) >>> 16));

            mx_reg  <= 51'(vx_reg) * 51'(h);
            my_reg  <= 51'(vy_reg) * 51'(h);
            px3_reg <= px2_reg;
            py3_reg <= py2_reg;
            th3_reg <= th2_reg;
            sp3_reg <= sp2_reg;
            wr3_reg <= wr2_reg;

            x4_reg  <= sat32(64'(px3_reg) + 64'((mx_reg + 51'sd32768) >>> 16));
            y4_reg  <= sat32(64'(py3_reg) + 64'((my_reg + 51'sd32768) >>> 16));
            th4_reg <= th3_reg;
            sp4_reg <= sp3_reg;
            wr4_reg <= wr3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign x_res     = x4_reg;
    assign y_res     = y4_reg;
    assign th_res    = th4_reg;
    assign sp_res    = sp4_reg;
    assign wr_res    = wr4_reg;

endmodule

// ===== hw/rtl/unicycle_euler_step_core.sv =====
// Top level of the unicycle Euler step core: angle reduction, CORDIC, scaling.
// Depends on ues_pkg, ues_if, ues_angle_reduce, ues_cordic and ues_scale_sat.

// One forward Euler step of a unicycle state per transfer. The core is a single
// stall-together pipeline: it takes one transfer on cur every cycle in which the
// output register is empty or nxt is taking its transfer. Each input passes in order
// through the reciprocal angle reduction, the CORDIC micro-rotations and a sign
// stage, then the multipliers and saturating sums. Write step_size through
// cfg_we/cfg_wdata only while no transfer is in flight; it resets to 655.
module unicycle_euler_step_core
    import ues_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    ues_in_if.sink           cur,
    ues_out_if.source        nxt
);

    logic [15:0] step_reg;
    logic        adv;
    side_t       in_side;

    logic                    ar_valid, ar_neg;
    logic signed [ANG_W-1:0] ar_z;
    side_t                   ar_side;

    logic                    cd_valid;
    logic signed [ANG_W-1:0] cd_cos, cd_sin;
    side_t                   cd_side;

    logic                    ss_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_RESET;
        else if (cfg_we)
            step_reg <= cfg_wdata;
    end

    // Advance the whole pipeline unless the output register is held
    assign adv       = ~ss_valid | nxt.ready;
    assign cur.ready = adv;
    assign nxt.valid = ss_valid;

    assign in_side = '{px: cur.pos_x, py: cur.pos_y, th: cur.heading, sp: cur.speed,
                       wr: cur.turn_rate, ac: cur.accel_cmd, tc: cur.turn_accel_cmd};

    ues_angle_reduce u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cur.valid),
        .in_side   (in_side),
        .out_valid (ar_valid),
        .out_z     (ar_z),
        .out_neg   (ar_neg),
        .out_side  (ar_side)
    );

    ues_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ar_valid),
        .in_z      (ar_z),
        .in_neg    (ar_neg),
        .in_side   (ar_side),
        .out_valid (cd_valid),
        .out_cos   (cd_cos),
        .out_sin   (cd_sin),
        .out_side  (cd_side)
    );

    ues_scale_sat u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .step      (step_reg),
        .in_valid  (cd_valid),
        .in_cos    (cd_cos),
        .in_sin    (cd_sin),
        .in_side   (cd_side),
        .out_valid (ss_valid),
        .x_res     (nxt.next_pos_x),
        .y_res     (nxt.next_pos_y),
        .th_res    (nxt.next_heading),
        .sp_res    (nxt.next_speed),
        .wr_res    (nxt.next_turn_rate)
    );

endmodule

// ===== hw/rtl/ues_checker.sv =====
// Port-level checks for the unicycle Euler step core, bound to the top level.
// Depends on assert_macros.svh and unicycle_euler_step_core.
`include "assert_macros.svh"

module ues_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x
);

    `UES_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
    `UES_ASSERT_SAME(a_ready_when_taken, out_ready, in_ready, "input stalled while output drains")
    `UES_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid, "result dropped under stall")
    `UES_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_x), "result changed under stall")

endmodule

bind unicycle_euler_step_core ues_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (cur.ready),
    .out_valid (nxt.valid),
    .out_ready (nxt.ready),
    .out_x     (nxt.next_pos_x)
);

// ===== tb/tb_pkg.sv =====
// Test-side predictor of one unicycle Euler step, Q16.16 fixed point.
// Depends on ues_pkg for the angle constants.
package tb_pkg;
    import ues_pkg::*;

    localparam int STAGES = 16;

    typedef struct {
        logic signed [31:0] px, py, th, sp, wr;
    } step_out_t;

    // atan(2^-i) in Q30, truncated
    localparam logic [31:0] ARCTAN_Q30 [30] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic step_out_t predict_step(input logic signed [31:0] px, py, th, sp,
                                               wr, ac, tc, input logic [15:0] h);
        step_out_t o;
        longint r, x, y, z, xs, ys, c, s, vx, vy, hh;
        bit flip;
        hh = longint'(h);
        r = longint'(th) % TWO_PI_Q;
        if (r < 0)
            r += TWO_PI_Q;
        if (r > PI_Q)
            r -= TWO_PI_Q;
        flip = 0;
        if (r > HALF_PI_Q)
        begin
            r -= PI_Q;
            flip = 1;
        end
        else if (r < -HALF_PI_Q)
        begin
            r += PI_Q;
            flip = 1;
        end
        z = r * 16384;
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= longint'(ARCTAN_Q30[i]);
            end
            else
            begin
                x += ys;
                y -= xs;
                z += longint'(ARCTAN_Q30[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        vx = rnd_shift(longint'(sp) * c, 30);
        vy = rnd_shift(longint'(sp) * s, 30);
        o.px = clamp32(longint'(px) + rnd_shift(vx * hh, 16));
        o.py = clamp32(longint'(py) + rnd_shift(vy * hh, 16));
        o.th = clamp32(longint'(th) + rnd_shift(longint'(wr) * hh, 16));
        o.sp = clamp32(longint'(sp) + rnd_shift(longint'(ac) * hh, 16));
        o.wr = clamp32(longint'(wr) + rnd_shift(longint'(tc) * hh, 16));
        return o;
    endfunction
endpackage

// ===== tb/tb.sv =====
// Testbench for unicycle_euler_step_core: directed and random state updates,
// checked against a local predictor. Depends on ues_pkg, ues_if, tb_pkg and unicycle_euler_step_core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic [15:0] step_now;
    int          n_err;
    int          ready_mode;
    step_out_t   expected_steps[$];

    ues_in_if  cur();
    ues_out_if nxt();

    unicycle_euler_step_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cur      (cur.sink),
        .nxt      (nxt.source)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stall pattern; mode 0 never stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            nxt.ready <= 0;
        else if (ready_mode == 0)
            nxt.ready <= 1;
        else
            nxt.ready <= (gap_len() == 0);
    end

    always @(posedge clk)
    begin
        step_out_t e;
        if (rst_n && nxt.valid && nxt.ready)
        begin
            if (expected_steps.size() == 0)
            begin
                $error("result with nothing expected");
                n_err++;
            end
            else
            begin
                e = expected_steps.pop_front();
                if (nxt.next_pos_x !== e.px)
                begin
                    $error("next_pos_x exp %0d got %0d", e.px, nxt.next_pos_x);
                    n_err++;
                end
                if (nxt.next_pos_y !== e.py)
                begin
                    $error("next_pos_y exp %0d got %0d", e.py, nxt.next_pos_y);
                    n_err++;
                end
                if (nxt.next_heading !== e.th)
                begin
                    $error("next_heading exp %0d got %0d", e.th, nxt.next_heading);
                    n_err++;
                end
                if (nxt.next_speed !== e.sp)
                begin
                    $error("next_speed exp %0d got %0d", e.sp, nxt.next_speed);
                    n_err++;
                end
                if (nxt.next_turn_rate !== e.wr)
                begin
                    $error("next_turn_rate exp %0d got %0d", e.wr, nxt.next_turn_rate);
                    n_err++;
                end
            end
        end
    end

    task automatic send_state(input logic signed [31:0] px, py, th, sp, wr, ac, tc,
                              input bit use_gaps);
        int g;
        g = use_gaps ? gap_len() : 0;
        repeat (g)
        begin
            cur.valid <= 0;
            @(negedge clk);
        end
        cur.valid          <= 1;
        cur.pos_x          <= px;
        cur.pos_y          <= py;
        cur.heading        <= th;
        cur.speed          <= sp;
        cur.turn_rate      <= wr;
        cur.accel_cmd      <= ac;
        cur.turn_accel_cmd <= tc;
        // wait for the transfer
        do
            @(posedge clk);
        while (!cur.ready);
        expected_steps.push_back(predict_step(px, py, th, sp, wr, ac, tc, step_now));
        @(negedge clk);
    endtask

    task automatic drain();
        int t;
        cur.valid <= 0;
        t = 0;
        while (expected_steps.size() != 0 && t < 100000)
        begin
            @(negedge clk);
            t++;
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic write_step(input logic [15:0] v);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 0;
        step_now = v;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'sh8000_0000 + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [31:0] mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        send_state(0, 0, 0, 0, 0, 0, 0, 0);
        send_state(mx, mx, mx, mx, mx, mx, mx, 0);
        send_state(mn, mn, mn, mn, mn, mn, mn, 0);
        send_state(mx, mn, 0, mx, mx, mx, mn, 0);
        send_state(mn, mx, 102944, mn, mn, mn, mx, 0);
        send_state(-1, -1, -1, -1, -1, -1, -1, 0);
        send_state(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                   32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 0);
        send_state(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                   32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 0);
    endtask

    // headings around the quadrant boundaries and whole turns
    task automatic test_heading_wrap();
        int angles[12] = '{102944, 102945, -102944, -102945, 205887, 205888,
                           -205887, -205888, 411775, -411775, 411774, 1000000};
        foreach (angles[i])
            send_state(0, 0, angles[i], 65536 * 3, 65536, 0, 0, 0);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_state(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), 1);
    endtask

    initial
    begin
        n_err      = 0;
        ready_mode = 0;
        step_now   = 16'd655;
        rst_n      = 0;
        cfg_we     = 0;
        cfg_wdata  = 0;
        cur.valid  = 0;
        cur.pos_x = 0; cur.pos_y = 0; cur.heading = 0; cur.speed = 0;
        cur.turn_rate = 0; cur.accel_cmd = 0; cur.turn_accel_cmd = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // reset step first, then the extremes of the register
        test_extremes();
        test_heading_wrap();
        drain();
        write_step(16'hFFFF);
        test_extremes();
        drain();
        write_step(16'h0000);
        test_extremes();
        drain();
        write_step(16'd1);
        test_heading_wrap();
        drain();

        ready_mode = 1;
        for (int p = 0; p < 4; p++)
        begin
            write_step(p == 3 ? 16'hFFFF : 16'($urandom));
            test_random(200);
            drain();
            ready_mode = (p % 2 == 0) ? 0 : 1;
        end

        if (n_err == 0 && expected_steps.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
